[src/pidc_pkg.sv]
// Shared constants and register indices for the clamped PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  // Fraction bits of the Q8.8 gains.
  localparam int FRAC_BITS = 8;

  // Field widths.
  localparam int DATA_W  = 16;  // setpoint, gains, measurement, drive
  localparam int UPPER_W = 15;  // unsigned upper limit
  localparam int ERR_W   = DATA_W + 1;
  localparam int SUM_W   = ERR_W + 1;      // error plus integral, also error difference
  localparam int IMAX_W  = UPPER_W - 1;
  localparam int PROD_W  = DATA_W + SUM_W; // widest product
  localparam int ACC_W   = PROD_W + 2;     // sum of three products

  // Configuration register indices.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOWER = 3'd5;

  // Reset values of the output limits.
  localparam logic [UPPER_W-1:0] UPPER_RESET = 15'h7FFF;
  localparam logic [DATA_W-1:0]  LOWER_RESET = 16'h8000;

  // Input mode codes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

endpackage

`default_nettype wire

[src/pid_controller_clamped_top.sv]
// Top level of the positional PID controller with integral clamping.
//
// Usage. Each request on the input channel (in_valid, in_stall, mode, measured)
// is either a measurement sample (mode 0) or a clear request (mode 1). Every
// request yields exactly one result on the output channel (out_valid,
// out_stall, drive). A request is taken at a rising edge where valid is high
// and stall is low, on either channel.
// A request taken into the input register is worked through in a single
// combinational pass (three multiplies in parallel, one sum, shift and
// clamp) before it is loaded into the result register that holds drive.
// Throughput is one request per cycle while the receiver does not stall,
// set by that single pass, since the integral and previous error are updated
// at the same edge that loads the result register.
// When the receiver stalls, the result is held; the input register keeps
// accepting until it too is full, after which in_stall rises.
// Reset clears both valid flags, the integral and the previous error, and
// returns the configuration registers to their reset values (zero setpoint
// and gains, full-scale limits). Configuration writes are always accepted
// (cfg_ready is high); indices beyond the sixth register are ignored.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_clamped_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              mode,
  input  wire logic signed [pidc_pkg::DATA_W-1:0] measured,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [pidc_pkg::DATA_W-1:0]     drive,
  // configuration channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pidc_pkg::DATA_W-1:0]       cfg_data
);
  import pidc_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0]  setpoint;
  logic signed [DATA_W-1:0]  gain_p;
  logic signed [DATA_W-1:0]  gain_i;
  logic signed [DATA_W-1:0]  gain_d;
  logic        [UPPER_W-1:0] drive_upper;
  logic signed [DATA_W-1:0]  drive_lower;

  // Controller state.
  logic signed [ERR_W-1:0] integral_sum;
  logic signed [ERR_W-1:0] prior_error;

  // Input register.
  logic                     s1_valid;
  logic                     mode_q;
  logic signed [DATA_W-1:0] measured_q;

  // Datapath.
  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_W-1:0]    isum_raw;
  logic signed [SUM_W-1:0]    imax_pos;
  logic signed [SUM_W-1:0]    imax_neg;
  logic signed [ERR_W-1:0]    isum;
  logic signed [SUM_W-1:0]    err_diff;
  logic signed [PROD_W-2:0]   prod_p;
  logic signed [PROD_W-2:0]   prod_i;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    res;
  logic signed [ACC_W-1:0]    upper_ext;
  logic signed [ACC_W-1:0]    lower_ext;
  logic signed [DATA_W-1:0]   drive_next;
  logic        [IMAX_W-1:0]   imax;

  logic out_free;
  logic advance;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= '0;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      drive_upper <= UPPER_RESET;
      drive_lower <= LOWER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SETPOINT:    setpoint    <= cfg_data;
        CFG_GAIN_P:      gain_p      <= cfg_data;
        CFG_GAIN_I:      gain_i      <= cfg_data;
        CFG_GAIN_D:      gain_d      <= cfg_data;
        CFG_DRIVE_UPPER: drive_upper <= cfg_data[UPPER_W-1:0];
        CFG_DRIVE_LOWER: drive_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the output register is free when empty or being drained, and
  // the input register moves on whenever the output register is free.
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_q     <= mode;
      measured_q <= measured;
    end
  end

  // Error and clamped integral.
  assign err = {setpoint[DATA_W-1], setpoint} - {measured_q[DATA_W-1], measured_q};
  assign isum_raw = {integral_sum[ERR_W-1], integral_sum} + {err[ERR_W-1], err};
  assign imax     = drive_upper[UPPER_W-1:1];
  assign imax_pos = $signed({{(SUM_W-IMAX_W){1'b0}}, imax});
  assign imax_neg = -imax_pos;

  always_comb begin
    if (isum_raw > imax_pos) begin
      isum = imax_pos[ERR_W-1:0];
    end else if (isum_raw < imax_neg) begin
      isum = imax_neg[ERR_W-1:0];
    end else begin
      isum = isum_raw[ERR_W-1:0];
    end
  end

  assign err_diff = {err[ERR_W-1], err} - {prior_error[ERR_W-1], prior_error};

  // Three independent products, summed exactly. Operands are sign-extended
  // to the product width first.
  assign prod_p = $signed({{(PROD_W-1-DATA_W){gain_p[DATA_W-1]}}, gain_p})
                * $signed({{(PROD_W-1-ERR_W){err[ERR_W-1]}}, err});
  assign prod_i = $signed({{(PROD_W-1-DATA_W){gain_i[DATA_W-1]}}, gain_i})
                * $signed({{(PROD_W-1-ERR_W){isum[ERR_W-1]}}, isum});
  assign prod_d = $signed({{(PROD_W-DATA_W){gain_d[DATA_W-1]}}, gain_d})
                * $signed({{(PROD_W-SUM_W){err_diff[SUM_W-1]}}, err_diff});

  assign acc = {{3{prod_p[PROD_W-2]}}, prod_p}
             + {{3{prod_i[PROD_W-2]}}, prod_i}
             + {{2{prod_d[PROD_W-1]}}, prod_d};

  // Arithmetic shift rounds toward minus infinity.
  assign res = acc >>> FRAC_BITS;

  assign upper_ext = $signed({{(ACC_W-UPPER_W){1'b0}}, drive_upper});
  assign lower_ext = {{(ACC_W-DATA_W){drive_lower[DATA_W-1]}}, drive_lower};

  // With crossed limits, a result above the upper limit gets the upper one, any other the lower one.
  always_comb begin
    if (mode_q == MODE_CLEAR) begin
      drive_next = '0;
    end else if (res > upper_ext) begin
      drive_next = {1'b0, drive_upper};
    end else if (res < lower_ext) begin
      drive_next = drive_lower;
    end else begin
      drive_next = res[DATA_W-1:0];
    end
  end

  // State update at the same edge that loads the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      prior_error  <= '0;
    end else if (advance) begin
      if (mode_q == MODE_CLEAR) begin
        integral_sum <= '0;
        prior_error  <= '0;
      end else begin
        integral_sum <= isum;
        prior_error  <= err;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= drive_next;
    end
  end

  // A clear request empties the state and yields a zero drive.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    advance && (mode_q == MODE_CLEAR) |=>
      out_valid && (drive == '0) && (integral_sum == '0) && (prior_error == '0))
    else $error("clear request did not zero the controller");

  // Every result obeys the upper limit, except where crossed limits give the
  // lower one.
  a_upper_bound: assert property (@(posedge clk) disable iff (rst)
    advance |=> ($signed(drive) <= $signed({1'b0, drive_upper})) || (drive == drive_lower))
    else $error("drive above upper limit");

  // A request held back by a stalled output is neither lost nor altered.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(measured_q) && $stable(mode_q))
    else $error("input register changed while blocked");

  // The state changes only when a request moves to the result register.
  a_state_stable: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(integral_sum) && $stable(prior_error))
    else $error("controller state changed without a request");

endmodule

`default_nettype wire
